>>> hdl/mps_pkg.sv
// Shared types and constants for the two-list median search block.
// No dependencies; mps_if, the search block, the checker and the testbench refer to it.
`timescale 1ns / 1ps

package mps_pkg;

    // Request kinds on the input channel.
    localparam logic [1:0] KIND_LOAD_A  = 2'd0;
    localparam logic [1:0] KIND_LOAD_B  = 2'd1;
    localparam logic [1:0] KIND_COMPUTE = 2'd2;

    // Result status codes.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [1:0] STATUS_NO_PART = 2'd2;

    // Element and result widths.
    localparam int ELEM_W   = 32;
    localparam int RESULT_W = 33;

    // Sequencer states of the partition search.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDR_LEFT,
        ST_ADDR_RIGHT,
        ST_EVAL,
        ST_DONE
    } mps_state_t;

endpackage

>>> hdl/mps_if.sv
// Valid/ready channel interfaces for requests and results of the median block.
// Depends on mps_pkg for the payload widths.
`timescale 1ns / 1ps

interface mps_in_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          kind;
    logic signed [mps_pkg::ELEM_W-1:0]   value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface mps_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [mps_pkg::RESULT_W-1:0] median_twice;
    logic [1:0]                          status;

    modport source (output valid, output median_twice, output status, input ready);
    modport sink   (input valid, input median_twice, input status, output ready);
endinterface

>>> hdl/mps_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module mps_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/median_two_sorted_partition_search.sv
// Channel   | Dir | Payload                                   | Handshake
// in_ch     | in  | kind[1:0], value[31:0] signed             | valid / ready
// out_ch    | out | median_twice[32:0] signed, status[1:0]    | valid / ready
//
// Load requests (kinds 0 and 1) are taken one per cycle while the sequencer is idle;
// each writes one RAM entry unless its list is full. A compute request runs a binary
// search over the shorter list: each probe is a left read, a right read and a compare,
// with at most floor(log2(n+1))+1 probes for a shorter list of n entries, between setup
// and result handoff; a final range check ends it when no partition is found.
// Reset clears the counts and the sequencer; list contents are not cleared.
// A result waiting on out_ch holds the sequencer in its final state until taken;
// load requests are accepted again as soon as the result register is loaded.
// Depends on mps_pkg, mps_if and mps_ram.
`timescale 1ns / 1ps

module median_two_sorted_partition_search #(
    parameter int MAX_LEN = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    mps_in_if.sink     in_ch,
    mps_out_if.source  out_ch
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW = CW + 1;
    localparam int EW = mps_pkg::ELEM_W;
    localparam int RW = mps_pkg::RESULT_W;

    // Control registers.
    mps_pkg::mps_state_t state_reg, state_next;
    logic [CW-1:0] count_a_reg, count_a_next;
    logic [CW-1:0] count_b_reg, count_b_next;
    logic          out_valid_reg, out_valid_next;

    // Search registers.
    logic          swap_reg, swap_next;
    logic          odd_reg, odd_next;
    logic [CW-1:0] ns_reg, ns_next;
    logic [CW-1:0] nl_reg, nl_next;
    logic [CW-1:0] left_reg, left_next;
    logic [LW-1:0] low_reg, low_next;
    logic [LW-1:0] hi1_reg, hi1_next;
    logic [CW-1:0] m1_reg, m1_next;
    logic [CW-1:0] m2_reg, m2_next;
    logic signed [EW-1:0] l1_reg, l1_next;
    logic signed [EW-1:0] l2_reg, l2_next;
    logic signed [RW-1:0] res_median_reg, res_median_next;
    logic [1:0]           res_status_reg, res_status_next;
    logic signed [RW-1:0] out_median_reg, out_median_next;
    logic [1:0]           out_status_reg, out_status_next;

    logic in_fire;
    logic [LW-1:0] total_c;
    logic [LW-1:0] mid_sum_c;
    logic [CW-1:0] m1_c;
    logic [CW-1:0] m2_c;
    logic [CW-1:0] sh_idx;
    logic [CW-1:0] lg_idx;
    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;
    logic [EW-1:0] rd_a;
    logic [EW-1:0] rd_b;
    logic signed [EW-1:0] sh_rd;
    logic signed [EW-1:0] lg_rd;
    logic l1v, l2v, r1v, r2v, ok1, ok2;
    logic signed [EW-1:0] lmax, rmin;
    logic signed [RW-1:0] twice_c;
    logic wr_a, wr_b;

    assign in_fire      = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = (state_reg == mps_pkg::ST_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.median_twice = out_median_reg;
    assign out_ch.status       = out_status_reg;

    // List appends go straight to the RAMs at the current fill count.
    assign wr_a = in_fire && (in_ch.kind == mps_pkg::KIND_LOAD_A)
                  && (count_a_reg < CW'(MAX_LEN));
    assign wr_b = in_fire && (in_ch.kind == mps_pkg::KIND_LOAD_B)
                  && (count_b_reg < CW'(MAX_LEN));

    // Probe point: m1 is the midpoint of the live range, m2 its partner cut.
    assign total_c   = LW'(count_a_reg) + LW'(count_b_reg);
    assign mid_sum_c = low_reg + hi1_reg - LW'(1);
    assign m1_c      = CW'(mid_sum_c >> 1);
    assign m2_c      = left_reg - m1_c;

    // The left neighbors are read first, then the right neighbors.
    always_comb
    begin
        if (state_reg == mps_pkg::ST_ADDR_LEFT)
        begin
            sh_idx = m1_c - CW'(1);
            lg_idx = m2_c - CW'(1);
        end
        else
        begin
            sh_idx = m1_reg;
            lg_idx = m2_reg;
        end
    end

    // Steer the shorter and longer lists onto the two physical RAMs.
    always_comb
    begin
        if (state_reg == mps_pkg::ST_IDLE)
        begin
            addr_a = count_a_reg[AW-1:0];
            addr_b = count_b_reg[AW-1:0];
        end
        else if (swap_reg)
        begin
            addr_a = lg_idx[AW-1:0];
            addr_b = sh_idx[AW-1:0];
        end
        else
        begin
            addr_a = sh_idx[AW-1:0];
            addr_b = lg_idx[AW-1:0];
        end
    end

    assign sh_rd = swap_reg ? rd_b : rd_a;
    assign lg_rd = swap_reg ? rd_a : rd_b;

    mps_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_LEN)
    ) u_ram_a (
        .clk     (clk),
        .wr_en   (wr_a),
        .wr_addr (count_a_reg[AW-1:0]),
        .wr_data (in_ch.value),
        .rd_addr (addr_a),
        .rd_data (rd_a)
    );

    mps_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_LEN)
    ) u_ram_b (
        .clk     (clk),
        .wr_en   (wr_b),
        .wr_addr (count_b_reg[AW-1:0]),
        .wr_data (in_ch.value),
        .rd_addr (addr_b),
        .rd_data (rd_b)
    );

    // Partition check: a missing neighbor never breaks the ordering.
    assign l1v = (m1_reg != '0);
    assign l2v = (m2_reg != '0);
    assign r1v = (m1_reg < ns_reg);
    assign r2v = (m2_reg < nl_reg);
    assign ok1 = !l1v || !r2v || (l1_reg <= lg_rd);
    assign ok2 = !l2v || !r1v || (l2_reg <= sh_rd);

    // Twice the median: twice the largest left element for an odd total, else its sum with the smallest right element.
    always_comb
    begin
        if (l1v && l2v)
        begin
            lmax = (l1_reg > l2_reg) ? l1_reg : l2_reg;
        end
        else
        begin
            lmax = l1v ? l1_reg : l2_reg;
        end
        if (r1v && r2v)
        begin
            rmin = (sh_rd < lg_rd) ? sh_rd : lg_rd;
        end
        else
        begin
            rmin = r1v ? sh_rd : lg_rd;
        end
        if (odd_reg)
        begin
            twice_c = {lmax, 1'b0};
        end
        else
        begin
            twice_c = {lmax[EW-1], lmax} + {rmin[EW-1], rmin};
        end
    end

    // Sequencer: next state and register updates.
    always_comb
    begin
        state_next      = state_reg;
        count_a_next    = count_a_reg;
        count_b_next    = count_b_reg;
        out_valid_next  = out_valid_reg;
        swap_next       = swap_reg;
        odd_next        = odd_reg;
        ns_next         = ns_reg;
        nl_next         = nl_reg;
        left_next       = left_reg;
        low_next        = low_reg;
        hi1_next        = hi1_reg;
        m1_next         = m1_reg;
        m2_next         = m2_reg;
        l1_next         = l1_reg;
        l2_next         = l2_reg;
        res_median_next = res_median_reg;
        res_status_next = res_status_reg;
        out_median_next = out_median_reg;
        out_status_next = out_status_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            mps_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_ch.kind)
                        mps_pkg::KIND_LOAD_A:
                        begin
                            if (wr_a)
                            begin
                                count_a_next = count_a_reg + CW'(1);
                            end
                        end
                        mps_pkg::KIND_LOAD_B:
                        begin
                            if (wr_b)
                            begin
                                count_b_next = count_b_reg + CW'(1);
                            end
                        end
                        mps_pkg::KIND_COMPUTE:
                        begin
                            count_a_next = '0;
                            count_b_next = '0;
                            if ((count_a_reg == '0) && (count_b_reg == '0))
                            begin
                                res_median_next = '0;
                                res_status_next = mps_pkg::STATUS_EMPTY;
                                state_next      = mps_pkg::ST_DONE;
                            end
                            else
                            begin
                                swap_next  = (count_a_reg > count_b_reg);
                                ns_next    = (count_a_reg > count_b_reg) ? count_b_reg
                                                                          : count_a_reg;
                                nl_next    = (count_a_reg > count_b_reg) ? count_a_reg
                                                                          : count_b_reg;
                                odd_next   = total_c[0];
                                left_next  = CW'((total_c + LW'(1)) >> 1);
                                low_next   = '0;
                                hi1_next   = ((count_a_reg > count_b_reg)
                                              ? LW'(count_b_reg) : LW'(count_a_reg))
                                             + LW'(1);
                                state_next = mps_pkg::ST_ADDR_LEFT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            mps_pkg::ST_ADDR_LEFT:
            begin
                if (low_reg < hi1_reg)
                begin
                    m1_next    = m1_c;
                    m2_next    = m2_c;
                    state_next = mps_pkg::ST_ADDR_RIGHT;
                end
                else
                begin
                    res_median_next = '0;
                    res_status_next = mps_pkg::STATUS_NO_PART;
                    state_next      = mps_pkg::ST_DONE;
                end
            end
            mps_pkg::ST_ADDR_RIGHT:
            begin
                l1_next    = sh_rd;
                l2_next    = lg_rd;
                state_next = mps_pkg::ST_EVAL;
            end
            mps_pkg::ST_EVAL:
            begin
                if (ok1 && ok2)
                begin
                    res_median_next = twice_c;
                    res_status_next = mps_pkg::STATUS_OK;
                    state_next      = mps_pkg::ST_DONE;
                end
                else
                begin
                    if (!ok1)
                    begin
                        hi1_next = LW'(m1_reg);
                    end
                    else
                    begin
                        low_next = LW'(m1_reg) + LW'(1);
                    end
                    state_next = mps_pkg::ST_ADDR_LEFT;
                end
            end
            mps_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_median_next = res_median_reg;
                    out_status_next = res_status_reg;
                    state_next      = mps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mps_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mps_pkg::ST_IDLE;
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_a_reg   <= count_a_next;
            count_b_reg   <= count_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        swap_reg       <= swap_next;
        odd_reg        <= odd_next;
        ns_reg         <= ns_next;
        nl_reg         <= nl_next;
        left_reg       <= left_next;
        low_reg        <= low_next;
        hi1_reg        <= hi1_next;
        m1_reg         <= m1_next;
        m2_reg         <= m2_next;
        l1_reg         <= l1_next;
        l2_reg         <= l2_next;
        res_median_reg <= res_median_next;
        res_status_reg <= res_status_next;
        out_median_reg <= out_median_next;
        out_status_reg <= out_status_next;
    end

endmodule

>>> hdl/mps_checker.sv
// Port-level checks for the median search block, bound to its top level.
// Depends on mps_pkg and on the ports of median_two_sorted_partition_search.
`timescale 1ns / 1ps

module mps_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic [1:0]                          in_kind,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [mps_pkg::RESULT_W-1:0] out_median,
    input logic [1:0]                          out_status
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_median) && $stable(out_status))
        else $error("result changed while stalled");

    // Any status other than ok carries a zero median.
    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status != mps_pkg::STATUS_OK) |-> (out_median == '0))
        else $error("nonzero median with failing status");

    // A compute request blocks further requests while the search runs.
    a_busy_after_compute: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_kind == mps_pkg::KIND_COMPUTE) |=> !in_ready)
        else $error("request taken during search");

    // A new result appears only as the search hands it off.
    a_result_from_search: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a search");

endmodule

bind median_two_sorted_partition_search mps_checker u_mps_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_kind    (in_ch.kind),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_median (out_ch.median_twice),
    .out_status (out_ch.status)
);

>>> tb/tb_median_two_sorted_partition_search.sv
// Self-checking testbench for median_two_sorted_partition_search.
// Drives load and compute requests, predicts twice the median of the two lists and
// checks every result. Depends on mps_pkg, mps_if and the block itself.
`timescale 1ns / 1ps

module tb_median_two_sorted_partition_search;

    localparam int MAX_LEN      = 1024;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_ITEMS = 520;
    localparam int ELEM_MAX     = 32'sh7FFFFFFF;
    localparam int ELEM_MIN     = 32'sh80000000;

    // Kind 3 has no meaning to the block; it must be dropped silently.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Ways the result side applies backpressure.
    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN,
        RX_SLOW
    } rx_mode_t;

    typedef struct packed {
        logic signed [mps_pkg::RESULT_W-1:0] median_twice;
        logic [1:0]                          status;
    } median_result_t;

    logic clk = 1'b0;
    logic rst_n;

    mps_in_if  in_ch();
    mps_out_if out_ch();

    median_two_sorted_partition_search #(
        .MAX_LEN(MAX_LEN)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Predictor copy of the two lists and their fill counts.
    int list_a_mem [MAX_LEN];
    int list_b_mem [MAX_LEN];
    int cnt_a = 0;
    int cnt_b = 0;

    median_result_t median_expect_q[$];

    // Sender and receiver pacing knobs.
    bit       tx_idle_en    = 1'b0;
    int       tx_burst_left = 0;
    int       noise_pct     = 0;
    rx_mode_t rx_mode       = RX_ALWAYS;
    int       rx_hold_left  = 0;
    int       rx_phase      = 0;

    int sent_items   = 0;
    int fail_count   = 0;
    int cycle_count  = 0;
    int stat_ok      = 0;
    int stat_empty   = 0;
    int stat_nopart  = 0;
    int stat_loads   = 0;
    int stat_dropped = 0;
    int stat_unused  = 0;
    int stat_checked = 0;

    always #5 clk = ~clk;

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("median_two_sorted_partition_search test failed");
            $finish;
        end
    end

    // Element of list B when from_b is set, else of list A.
    function automatic int list_elem(input bit from_b, input int idx);
        return from_b ? list_b_mem[idx] : list_a_mem[idx];
    endfunction

    // Binary search over splits of the shorter list; returns twice the median.
    function automatic median_result_t predict_median();
        median_result_t res;
        bit     b_short, found;
        bit     l1v, l2v, r1v, r2v, ok1, ok2;
        int     ns, nl, half, lo, hi, m1, m2;
        int     l1, l2, r1, r2, lmax, rmin;
        longint twice;
        res.median_twice = '0;
        res.status       = mps_pkg::STATUS_NO_PART;
        found            = 1'b0;
        twice            = 0;
        if (cnt_a == 0 && cnt_b == 0)
        begin
            res.status = mps_pkg::STATUS_EMPTY;
            return res;
        end
        // List A is the searched one when both lengths match.
        b_short = cnt_a > cnt_b;
        ns      = b_short ? cnt_b : cnt_a;
        nl      = b_short ? cnt_a : cnt_b;
        half    = (ns + nl + 1) / 2;
        lo      = 0;
        hi      = ns;
        while (!found && lo <= hi)
        begin
            m1  = (lo + hi) / 2;
            m2  = half - m1;
            l1v = m1 > 0;
            l2v = m2 > 0;
            r1v = m1 < ns;
            r2v = m2 < nl;
            l1  = l1v ? list_elem(b_short, m1 - 1) : 0;
            l2  = l2v ? list_elem(!b_short, m2 - 1) : 0;
            r1  = r1v ? list_elem(b_short, m1) : 0;
            r2  = r2v ? list_elem(!b_short, m2) : 0;
            // A neighbor past the list edge never breaks the ordering test.
            ok1 = !l1v || !r2v || (l1 <= r2);
            ok2 = !l2v || !r1v || (l2 <= r1);
            if (ok1 && ok2)
            begin
                found = 1'b1;
                if (l1v && l2v)
                    lmax = (l1 > l2) ? l1 : l2;
                else
                    lmax = l1v ? l1 : l2;
                if (r1v && r2v)
                    rmin = (r1 < r2) ? r1 : r2;
                else
                    rmin = r1v ? r1 : r2;
                if ((ns + nl) % 2 == 1)
                    twice = 2 * longint'(lmax);
                else
                    twice = longint'(lmax) + longint'(rmin);
            end
            else if (!ok1)
                hi = m1 - 1;
            else
                lo = m1 + 1;
        end
        if (found)
        begin
            res.status       = mps_pkg::STATUS_OK;
            res.median_twice = twice[mps_pkg::RESULT_W-1:0];
        end
        return res;
    endfunction

    // Update the predicted lists, or queue a prediction, for one accepted request.
    task automatic apply_request(input logic [1:0] kind, input logic [31:0] value);
        median_result_t res;
        case (kind)
            mps_pkg::KIND_LOAD_A:
            begin
                stat_loads++;
                if (cnt_a < MAX_LEN)
                begin
                    list_a_mem[cnt_a] = int'(value);
                    cnt_a++;
                end
                else
                    stat_dropped++;
            end
            mps_pkg::KIND_LOAD_B:
            begin
                stat_loads++;
                if (cnt_b < MAX_LEN)
                begin
                    list_b_mem[cnt_b] = int'(value);
                    cnt_b++;
                end
                else
                    stat_dropped++;
            end
            mps_pkg::KIND_COMPUTE:
            begin
                res = predict_median();
                case (res.status)
                    mps_pkg::STATUS_OK:    stat_ok++;
                    mps_pkg::STATUS_EMPTY: stat_empty++;
                    default:               stat_nopart++;
                endcase
                median_expect_q.push_back(res);
                cnt_a = 0;
                cnt_b = 0;
            end
            default:
                stat_unused++;
        endcase
    endtask

    // Watch the request channel and feed accepted requests to the predictor.
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            apply_request(in_ch.kind, in_ch.value);
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        median_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            stat_checked++;
            if (median_expect_q.size() == 0)
            begin
                $error("Unexpected result: median_twice %0d, status %0d",
                       $signed(out_ch.median_twice), out_ch.status);
                fail_count++;
            end
            else
            begin
                want = median_expect_q.pop_front();
                if (out_ch.median_twice !== want.median_twice)
                begin
                    $error("median_twice mismatch: expected %0d, actual %0d",
                           $signed(want.median_twice), $signed(out_ch.median_twice));
                    fail_count++;
                end
                if (out_ch.status !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, out_ch.status);
                    fail_count++;
                end
            end
        end
    end

    // Result-side ready: a long hold when requested, otherwise the current pattern.
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                rx_hold_left--;
            end
            else
            begin
                case (rx_mode)
                    RX_ALWAYS:  out_ch.ready <= 1'b1;
                    RX_RANDOM:  out_ch.ready <= 1'($urandom_range(0, 1));
                    RX_PATTERN: out_ch.ready <= (rx_phase % 7) < 4;
                    default:    out_ch.ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
            rx_phase++;
        end
    end

    // Offer one request and hold it until the block accepts it.
    task automatic send_request(input logic [1:0] kind, input logic [31:0] value);
        int gap;
        if (tx_idle_en && tx_burst_left <= 0)
        begin
            gap           = $urandom_range(1, 8);
            tx_burst_left = $urandom_range(1, 12);
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.kind  <= kind;
        in_ch.value <= value;
        forever
        begin
            @(posedge clk);
            if (in_ch.ready)
                break;
        end
        tx_burst_left--;
        if (kind != KIND_UNUSED)
            sent_items++;
    endtask

    // Load both lists in a random interleaving, then ask for the median.
    task automatic send_lists(input int qa[$], input int qb[$]);
        int ia, ib;
        ia = 0;
        ib = 0;
        while (ia < qa.size() || ib < qb.size())
        begin
            if (noise_pct > 0 && $urandom_range(0, 99) < noise_pct)
                send_request(KIND_UNUSED, $urandom());
            if (ib >= qb.size() || (ia < qa.size() && $urandom_range(0, 1) == 1))
            begin
                send_request(mps_pkg::KIND_LOAD_A, qa[ia]);
                ia++;
            end
            else
            begin
                send_request(mps_pkg::KIND_LOAD_B, qb[ib]);
                ib++;
            end
        end
        send_request(mps_pkg::KIND_COMPUTE, $urandom());
    endtask

    // Drop valid, then wait until every predicted result has been taken.
    task automatic wait_drained();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (median_expect_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Build a list of n elements, ascending with duplicates or fully random.
    function automatic void make_list(output int q[$], input int n, input bit sorted);
        longint      cur;
        int unsigned step_max;
        q.delete();
        case ($urandom_range(0, 3))
            0:       cur = ELEM_MIN;
            1:       cur = longint'($signed($urandom()));
            2:       cur = longint'($urandom_range(0, 20)) - 10;
            default: cur = longint'(ELEM_MAX) - $urandom_range(0, 50);
        endcase
        case ($urandom_range(0, 2))
            0:       step_max = 2;
            1:       step_max = 1000;
            default: step_max = 32'h1000_0000;
        endcase
        for (int i = 0; i < n; i++)
        begin
            if (sorted)
            begin
                q.push_back(int'(cur));
                cur += $urandom_range(0, step_max);
                if (cur > ELEM_MAX)
                    cur = ELEM_MAX;
            end
            else if ($urandom_range(0, 1) == 1)
                q.push_back(int'($urandom()));
            else
                q.push_back(int'($urandom_range(0, 8)) - 4);
        end
    endfunction

    // Mostly short lists, now and then a long one.
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(0, 6);
        else if (r < 85)
            return $urandom_range(0, 16);
        else if (r < 98)
            return $urandom_range(17, 64);
        return $urandom_range(65, 300);
    endfunction

    function automatic void retune_idling();
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_mode    = rx_mode_t'($urandom_range(0, 3));
    endfunction

    // Extreme values, edge-of-list neighbors, equal lengths, empty and unsorted lists.
    task automatic test_directed();
        int qa[$], qb[$];
        tx_idle_en = 1'b0;
        rx_mode    = RX_ALWAYS;
        noise_pct  = 0;
        // Compute with nothing loaded.
        qa.delete();
        qb.delete();
        send_lists(qa, qb);
        // Single element in either list.
        qa = {ELEM_MAX};
        send_lists(qa, qb);
        qa.delete();
        qb = {ELEM_MIN};
        send_lists(qa, qb);
        // Largest and smallest even-total sums.
        qa = {ELEM_MAX};
        qb = {ELEM_MAX};
        send_lists(qa, qb);
        qa = {ELEM_MIN};
        qb = {ELEM_MIN};
        send_lists(qa, qb);
        // Equal lengths with every element of A on the left side.
        qa = {1, 2};
        qb = {3, 4};
        send_lists(qa, qb);
        // An unused kind between loads must change nothing.
        send_request(KIND_UNUSED, $urandom());
        qa = {7, 8, 9};
        qb = {-3};
        send_lists(qa, qb);
        // Unsorted input.
        qa = {5, 1, 3};
        qb = {3, 0};
        send_lists(qa, qb);
        wait_drained();
    endtask

    // Overfill list A; appends past the store depth must be dropped.
    task automatic test_full_list();
        int qa[$], qb[$];
        tx_idle_en = 1'b1;
        rx_mode    = RX_RANDOM;
        noise_pct  = 0;
        for (int i = 0; i < MAX_LEN + 2; i++)
            qa.push_back(i * 4);
        qb = {1, 2049};
        send_lists(qa, qb);
        wait_drained();
    endtask

    // Hold results off for a long stretch so the block stalls its input.
    task automatic test_backpressure();
        int qa[$], qb[$];
        tx_idle_en   = 1'b0;
        rx_mode      = RX_ALWAYS;
        noise_pct    = 0;
        rx_hold_left = 400;
        qa = {1, 2, 3};
        qb = {4};
        send_lists(qa, qb);
        qa = {-10};
        qb = {20, 30};
        send_lists(qa, qb);
        qa = {7, 7};
        qb = {7, 7};
        send_lists(qa, qb);
        wait_drained();
    endtask

    // Mostly sorted list pairs with random content, plus unsorted, empty and noisy ones.
    task automatic test_random();
        int qa[$], qb[$];
        int start, pick;
        start = sent_items;
        retune_idling();
        while (sent_items - start < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 15) == 0)
                retune_idling();
            pick      = $urandom_range(0, 99);
            noise_pct = (pick >= 97) ? 40 : 4;
            if (pick < 80 || pick >= 97)
            begin
                make_list(qa, pick_len(), 1'b1);
                make_list(qb, pick_len(), 1'b1);
            end
            else if (pick < 92)
            begin
                make_list(qa, pick_len(), 1'b0);
                make_list(qb, pick_len(), 1'b0);
            end
            else
            begin
                qa.delete();
                qb.delete();
            end
            send_lists(qa, qb);
        end
        wait_drained();
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.kind  = mps_pkg::KIND_LOAD_A;
        in_ch.value = '0;
        rst_n       = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_full_list();
        test_backpressure();
        test_random();

        $display("Checked %0d medians: %0d ok, %0d with empty lists, %0d without a partition.",
                 stat_checked, stat_ok, stat_empty, stat_nopart);
        $display("Sent %0d list loads (%0d dropped on a full list) and %0d unused-kind requests.",
                 stat_loads, stat_dropped, stat_unused);
        if (fail_count == 0)
            $display("median_two_sorted_partition_search test passed");
        else
            $display("median_two_sorted_partition_search test failed");
        $finish;
    end

endmodule

>>> filelist.f
hdl/mps_pkg.sv
hdl/mps_if.sv
hdl/mps_ram.sv
hdl/median_two_sorted_partition_search.sv
hdl/mps_checker.sv
tb/tb_median_two_sorted_partition_search.sv
